/* hw/rtl/thec_pkg.sv */
// Shared types, constants and helper functions for the tilde hex escape codec.
// Used by the front, queue, back and top level modules. No dependencies.
`timescale 1ns / 1ps

package thec_pkg;

  localparam logic [7:0] TildeChar  = 8'h7e;
  localparam logic [7:0] PrintLow   = 8'h20;
  localparam logic [7:0] PrintHigh  = 8'h7d;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCw    = $clog2(QDepth + 1);

  localparam logic [QAw-1:0] QPtrLast = QAw'(QDepth - 1);
  localparam logic [QCw-1:0] QFull    = QCw'(QDepth);

  // Register map: byte address bit 2 selects the register index.
  localparam logic RegDecodeMode = 1'b0;

  // Beat codes within an escaped triple.
  localparam logic [1:0] BeatTilde = 2'd0;
  localparam logic [1:0] BeatHigh  = 2'd1;
  localparam logic [1:0] BeatLow   = 2'd2;

  // One queued job: either a single result or an encode escape triple.
  typedef struct packed {
    logic       esc;
    logic [7:0] data;
    logic       last;
    logic       bad;
  } job_t;

  typedef struct packed {
    logic           not_empty;
    logic           full;
    logic [QCw-1:0] count;
    job_t           head;
  } q_status_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_value(input logic [7:0] c);
    hex_digit_t r;
    r.ok    = 1'b1;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = 4'(c - 8'h61 + 8'd10);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'd0, v};
    end else begin
      r = 8'h61 + {4'd0, v} - 8'd10;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/thec_front.sv */
// Front end of the codec: accepts input beats, runs the decode escape state
// and classifies each byte that gives a result into a queued job. Depends on thec_pkg.
`timescale 1ns / 1ps

module thec_front import thec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       decode_mode,
  input  logic       clear,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       push,
  output job_t       job
);

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhFirst  = 2'd1;
  localparam logic [1:0] PhSecond = 2'd2;
  localparam logic [1:0] PhSwallow = 2'd3;

  logic [1:0] phase, phase_next;
  logic [3:0] high_nibble, high_nibble_next;
  hex_digit_t digit;
  logic       want;

  assign digit = hex_value(in_byte);

  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    want             = 1'b0;
    job.esc          = 1'b0;
    job.data         = in_byte;
    job.last         = in_last;
    job.bad          = 1'b0;
    if (!decode_mode) begin
      want    = 1'b1;
      job.esc = !(in_byte >= PrintLow && in_byte <= PrintHigh);
    end else begin
      case (phase)
        PhIdle: begin
          if (in_byte == TildeChar) begin
            if (in_last) begin
              want     = 1'b1;
              job.data = 8'd0;
              job.last = 1'b1;
              job.bad  = 1'b1;
            end else begin
              phase_next = PhFirst;
            end
          end else begin
            want = 1'b1;
          end
        end
        PhFirst: begin
          if (!digit.ok || in_last) begin
            want       = 1'b1;
            job.data   = 8'd0;
            job.last   = 1'b1;
            job.bad    = 1'b1;
            phase_next = in_last ? PhIdle : PhSwallow;
          end else begin
            high_nibble_next = digit.value;
            phase_next       = PhSecond;
          end
        end
        PhSecond: begin
          want = 1'b1;
          if (!digit.ok) begin
            job.data   = 8'd0;
            job.last   = 1'b1;
            job.bad    = 1'b1;
            phase_next = in_last ? PhIdle : PhSwallow;
          end else begin
            job.data   = {high_nibble, digit.value};
            phase_next = PhIdle;
          end
        end
        default: begin
          if (in_last) begin
            phase_next = PhIdle;
          end
        end
      endcase
    end
  end

  assign push = accept && want;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase       <= PhIdle;
      high_nibble <= 4'd0;
    end else if (accept) begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
    end
  end

endmodule

/* hw/rtl/thec_queue.sv */
// Short job queue between the front and back of the codec.
// Depends on thec_pkg for the job type and depth constants.
`timescale 1ns / 1ps

module thec_queue import thec_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output q_status_t status
);

  job_t           slots [QDepth];
  logic [QAw-1:0] wr_ptr, rd_ptr;
  logic [QCw-1:0] count;

  assign status.not_empty = (count != '0);
  assign status.full      = (count == QFull);
  assign status.count     = count;
  assign status.head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrLast) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/thec_back.sv */
// Back end of the codec: expands queued jobs into result beats, one per
// cycle unless the output stalls, into the output register. Depends on thec_pkg.
`timescale 1ns / 1ps

module thec_back import thec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  q_status_t  q_status,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       bad_escape
);

  logic [1:0] beat;
  logic       load;
  logic       final_beat;
  logic [7:0] beat_byte;
  logic       beat_last;
  job_t       head;

  assign head = q_status.head;
  assign load = !out_valid || !out_stall;
  assign final_beat = !head.esc || (beat == BeatLow);
  assign pop = load && q_status.not_empty && final_beat;

  always_comb begin
    beat_byte = head.data;
    beat_last = head.last;
    if (head.esc) begin
      case (beat)
        BeatTilde: begin
          beat_byte = TildeChar;
          beat_last = 1'b0;
        end
        BeatHigh: begin
          beat_byte = hex_char(head.data[7:4]);
          beat_last = 1'b0;
        end
        default: begin
          beat_byte = hex_char(head.data[3:0]);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat      <= BeatTilde;
    end else if (load) begin
      out_valid <= q_status.not_empty;
      if (q_status.not_empty) begin
        beat <= final_beat ? BeatTilde : beat + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_status.not_empty) begin
      out_byte   <= beat_byte;
      out_last   <= beat_last;
      bad_escape <= head.bad && !head.esc;
    end
  end

endmodule

/* hw/rtl/tilde_hex_escape_codec_top.sv */
// Top level of the tilde hex escape codec: register port, front, queue, back.
// Depends on thec_pkg, thec_front, thec_queue and thec_back.
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   in_byte[7:0], in_last
// result    out        out_valid / out_stall out_byte[7:0], out_last, bad_escape
// config    APB write  psel/penable/pwrite   paddr[2:0], pwdata[31:0]
//
// An input beat is accepted whenever the job queue has room. Each result
// beat occupies the output register on its own, so a pass-through or decoded
// byte gives one result beat and an escaped byte in encode mode three; the
// output register, one beat per cycle unless stalled, sets the sustained rate.
// Reset (rst, synchronous) empties the queue and output register, selects
// encode mode and clears the escape state. A stalled output holds its beat
// while the front keeps accepting until the four-entry queue fills.

module tilde_hex_escape_codec_top import thec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        bad_escape,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic      decode_mode;
  logic      cfg_write;
  logic      mode_write;
  logic      accept;
  logic      push;
  logic      pop;
  job_t      job;
  q_status_t q_status;

  // The register port never waits. Bit 2 of the byte address picks the
  // register; only index zero exists and the rest read as zero.
  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign mode_write = cfg_write && (paddr[2] == RegDecodeMode);
  assign prdata     = (paddr[2] == RegDecodeMode) ? {31'd0, decode_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= 1'b0;
    end else if (mode_write) begin
      decode_mode <= pwdata[0];
    end
  end

  // The front stalls only when the queue is full; items that cause no
  // result (escape openers, first digits, swallowed bytes) push nothing.
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  thec_front u_front (
    .clk         (clk),
    .rst         (rst),
    .decode_mode (decode_mode),
    .clear       (mode_write),
    .accept      (accept),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .push        (push),
    .job         (job)
  );

  thec_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .status   (q_status)
  );

  thec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .bad_escape (bad_escape)
  );

  // An error beat always carries a zero byte and ends the message.
  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_escape |-> out_last && (out_byte == 8'd0))
    else $error("error beat without last or with nonzero byte");

  // The queue never pushes while full without a pop and never pops while empty.
  a_queue_bounds: assert property (@(posedge clk) disable iff (rst)
    !(push && q_status.full && !pop) && !(pop && !q_status.not_empty))
    else $error("queue overflow or underflow");

  // A pushed job is visible to the back end in the next cycle.
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push |=> q_status.not_empty)
    else $error("pushed job lost");

  // Encode mode never produces an error beat from a job pushed in that mode.
  a_encode_clean: assert property (@(posedge clk) disable iff (rst)
    push && !decode_mode |-> !job.bad)
    else $error("error job in encode mode");

endmodule

/* dv/tb_tilde_hex_escape_codec_top.sv */
// Self-checking testbench for the tilde hex escape codec top level.
// Depends on thec_pkg and tilde_hex_escape_codec_top, which uses thec_front, thec_queue and thec_back.
`timescale 1ns / 1ps

module tb_tilde_hex_escape_codec_top;
  import thec_pkg::*;

  // Byte addresses of the two register slots. Only the first one holds a register;
  // the second is an unused index whose writes must leave the block unchanged.
  localparam logic [2:0] AddrMode  = {RegDecodeMode, 2'b00};
  localparam logic [2:0] AddrSpare = 3'd4;

  // Enough cycles for the queue and output register to empty after the last
  // expected beat, covering swallowed bytes that are still in flight.
  localparam int QuietCycles = 12;
  localparam int PhaseItems  = 55;

  localparam logic [7:0] Ascii0      = 8'h30;
  localparam logic [7:0] Ascii9      = 8'h39;
  localparam logic [7:0] AsciiUpperA = 8'h41;
  localparam logic [7:0] AsciiUpperF = 8'h46;
  localparam logic [7:0] AsciiLowerA = 8'h61;
  localparam logic [7:0] AsciiLowerF = 8'h66;

  typedef enum logic [1:0] {
    PhaseOutside = 2'd0,
    PhaseHigh    = 2'd1,
    PhaseLow     = 2'd2,
    PhaseDrain   = 2'd3
  } esc_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } codec_beat_t;

  // The scoreboard holds its own copy of the mode and escape state. Each
  // accepted input beat is turned into the result beats it should cause,
  // and each result beat off the block is matched against the oldest one.
  class escape_scoreboard;
    logic          decode_on;
    esc_phase_t    phase;
    logic [3:0]    high_digit;
    codec_beat_t   pending_beats[$];
    int            mismatches;
    int            beats_checked;
    int            flagged_beats;

    function new();
      decode_on     = 1'b0;
      phase         = PhaseOutside;
      high_digit    = 4'd0;
      mismatches    = 0;
      beats_checked = 0;
      flagged_beats = 0;
    endfunction

    // A mode write also abandons any escape in progress.
    function void load_mode(logic m);
      decode_on  = m;
      phase      = PhaseOutside;
      high_digit = 4'd0;
    endfunction

    function int digit_of(logic [7:0] c);
      if (c >= Ascii0 && c <= Ascii9) return int'(c - Ascii0);
      if (c >= AsciiUpperA && c <= AsciiUpperF) return int'(c - AsciiUpperA) + 10;
      if (c >= AsciiLowerA && c <= AsciiLowerF) return int'(c - AsciiLowerA) + 10;
      return -1;
    endfunction

    function logic [7:0] nibble_char(logic [3:0] v);
      if (v < 4'd10) return Ascii0 + {4'd0, v};
      return AsciiLowerA + {4'd0, v} - 8'd10;
    endfunction

    function void flag_escape(logic l);
      pending_beats.push_back('{data: 8'h00, last: 1'b1, bad: 1'b1});
      phase = l ? PhaseOutside : PhaseDrain;
    endfunction

    function void absorb_byte(logic [7:0] b, logic l);
      int v;
      v = digit_of(b);
      if (!decode_on) begin
        if (b >= PrintLow && b <= PrintHigh) begin
          pending_beats.push_back('{data: b, last: l, bad: 1'b0});
        end else begin
          pending_beats.push_back('{data: TildeChar, last: 1'b0, bad: 1'b0});
          pending_beats.push_back('{data: nibble_char(b[7:4]), last: 1'b0, bad: 1'b0});
          pending_beats.push_back('{data: nibble_char(b[3:0]), last: l, bad: 1'b0});
        end
        return;
      end
      case (phase)
        PhaseOutside: begin
          if (b != TildeChar) begin
            pending_beats.push_back('{data: b, last: l, bad: 1'b0});
          end else if (l) begin
            flag_escape(1'b1);
          end else begin
            phase = PhaseHigh;
          end
        end
        PhaseHigh: begin
          if (v < 0 || l) begin
            flag_escape(l);
          end else begin
            high_digit = v[3:0];
            phase      = PhaseLow;
          end
        end
        PhaseLow: begin
          if (v < 0) begin
            flag_escape(l);
          end else begin
            pending_beats.push_back('{data: {high_digit, v[3:0]}, last: l, bad: 1'b0});
            phase = PhaseOutside;
          end
        end
        default: begin
          if (l) phase = PhaseOutside;
        end
      endcase
    endfunction

    function void check_beat(logic [7:0] d, logic l, logic bad);
      codec_beat_t want;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected result beat: actual byte=%02h last=%b bad=%b",
                 $time, d, l, bad);
        mismatches++;
        return;
      end
      want = pending_beats.pop_front();
      beats_checked++;
      if (bad) flagged_beats++;
      if (d !== want.data || l !== want.last || bad !== want.bad) begin
        $display("%0t: result mismatch: expected byte=%02h last=%b bad=%b",
                 $time, want.data, want.last, want.bad);
        $display("%0t:                   actual byte=%02h last=%b bad=%b",
                 $time, d, l, bad);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        bad_escape;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  escape_scoreboard sb;
  logic [7:0]       msg_bytes[$];
  logic             steady;
  int               items_sent;
  int               mode_writes;
  int               pauses;

  tilde_hex_escape_codec_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .bad_escape (bad_escape),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: every beat that leaves the block is checked at the rising
  // edge where the handshake completes. Outputs settle before that edge,
  // since stimulus only moves on falling edges.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_beat(out_byte, out_last, bad_escape);
    end
  end

  // Receiver back-pressure: alternating free runs and stall runs. A few stall
  // runs are long enough to fill the queue, and now and then a long free run
  // lets the block stream at full rate.
  initial begin
    int run;
    int hold;
    out_stall = 1'b0;
    forever begin
      run  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      hold = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      repeat (run) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
    end
  end

  // Sender gap before a beat: none while steady, otherwise usually none, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Offers one input beat and holds it until the block takes it. Valid is
  // either kept high for back-to-back beats or lowered for a gap, never both
  // in the same falling edge.
  task automatic push_beat(input logic [7:0] b, input logic l);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    do @(posedge clk); while (in_stall);
    sb.absorb_byte(b, l);
    items_sent++;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++) begin
      push_beat(msg_bytes[i], i == msg_bytes.size() - 1);
    end
  endtask

  // Stops sending and waits until every predicted beat has come out, then
  // lets the block run dry of bytes that produce nothing.
  task automatic drain_and_wait();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (QuietCycles) @(posedge clk);
    pauses++;
  endtask

  // One register access: setup cycle, then access cycle until pready. A read
  // of the mode register is compared against the scoreboard's copy.
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) mode_writes++;
    if (wr && addr == AddrMode) sb.load_mode(data[0]);
    if (!wr && addr == AddrMode && prdata !== {31'd0, sb.decode_on}) begin
      $display("%0t: mode readback mismatch: expected %08h, actual %08h",
               $time, {31'd0, sb.decode_on}, prdata);
      sb.mismatches++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mode changes happen only with the block idle. The upper data bits are
  // random and must be ignored.
  task automatic set_mode(input logic m);
    logic [31:0] w;
    w    = $urandom();
    w[0] = m;
    drain_and_wait();
    apb_access(1'b1, AddrMode, w);
    apb_access(1'b0, AddrMode, 32'd0);
  endtask

  function automatic logic [7:0] random_digit_char();
    logic [3:0] v;
    v = 4'($urandom_range(0, 15));
    if (v < 4'd10) return Ascii0 + {4'd0, v};
    if ($urandom_range(0, 1) == 1) return AsciiUpperA + {4'd0, v} - 8'd10;
    return AsciiLowerA + {4'd0, v} - 8'd10;
  endfunction

  function automatic logic [7:0] random_non_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (sb.digit_of(b) >= 0);
    return b;
  endfunction

  // Raw message for encode mode: a mix of uniform bytes, printable text, bytes
  // at and near the pass-through borders (1f, the tilde, 7f) and 00, 80 and ff.
  task automatic build_raw_message();
    int len;
    int r;
    len = $urandom_range(1, 8);
    msg_bytes.delete();
    repeat (len) begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        msg_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 8) begin
        msg_bytes.push_back(8'($urandom_range(PrintLow, PrintHigh)));
      end else begin
        case ($urandom_range(0, 5))
          0: msg_bytes.push_back(TildeChar);
          1: msg_bytes.push_back(PrintHigh + 8'd2);
          2: msg_bytes.push_back(PrintLow - 8'd1);
          3: msg_bytes.push_back(8'h00);
          4: msg_bytes.push_back(8'h80);
          default: msg_bytes.push_back(8'hff);
        endcase
      end
    end
  endtask

  // Escaped text for decode mode. Most tokens are literals or well-formed
  // escapes; a few are broken, either with a bad digit (the rest of the
  // message is then swallowed) or cut off by the end of the message.
  task automatic build_escaped_message();
    int tokens;
    int r;
    logic [7:0] b;
    tokens = $urandom_range(1, 6);
    msg_bytes.delete();
    for (int t = 0; t < tokens; t++) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        do b = 8'($urandom_range(0, 255)); while (b == TildeChar);
        msg_bytes.push_back(b);
      end else if (r < 93) begin
        msg_bytes.push_back(TildeChar);
        msg_bytes.push_back(random_digit_char());
        msg_bytes.push_back(random_digit_char());
      end else begin
        msg_bytes.push_back(TildeChar);
        case ($urandom_range(0, 3))
          0: msg_bytes.push_back(random_non_digit());
          1: begin
            msg_bytes.push_back(random_digit_char());
            msg_bytes.push_back(random_non_digit());
          end
          2: break;
          default: begin
            msg_bytes.push_back(random_digit_char());
            break;
          end
        endcase
      end
    end
  endtask

  task automatic run_phase(input logic m);
    int start;
    start = items_sent;
    set_mode(m);
    while (items_sent - start < PhaseItems) begin
      steady = ($urandom_range(0, 3) == 0);
      if (m) build_escaped_message();
      else build_raw_message();
      send_message();
      if ($urandom_range(0, 15) == 0) drain_and_wait();
    end
    steady = 1'b0;
  endtask

  initial begin
    sb          = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_byte     = 8'h00;
    in_last     = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = 3'd0;
    pwdata      = 32'd0;
    steady      = 1'b0;
    items_sent  = 0;
    mode_writes = 0;
    pauses      = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Encode mode straight out of reset: both borders of the pass-through
    // range, the tilde itself, a control byte, DEL and the top byte.
    push_beat(8'h00, 1'b0);
    push_beat(PrintLow - 8'd1, 1'b0);
    push_beat(PrintLow, 1'b0);
    push_beat(PrintHigh, 1'b0);
    push_beat(TildeChar, 1'b0);
    push_beat(8'h7f, 1'b0);
    push_beat(8'hff, 1'b1);

    // Decode mode. A write to the unused index must not disturb the mode.
    set_mode(1'b1);
    apb_access(1'b1, AddrSpare, 32'hffff_fffe);
    apb_access(1'b0, AddrMode, 32'd0);

    // Literals, including a zero byte, then escapes with digits in both cases.
    push_beat(8'h78, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(TildeChar, 1'b0);
    push_beat(AsciiUpperF, 1'b0);
    push_beat(AsciiLowerA, 1'b0);
    push_beat(TildeChar, 1'b0);
    push_beat(Ascii9, 1'b0);
    push_beat(AsciiLowerF - 8'd4, 1'b1);

    // Bad first digit in mid-message: one error beat, then the rest of the
    // message is swallowed up to its last byte.
    push_beat(TildeChar, 1'b0);
    push_beat(AsciiLowerF + 8'd1, 1'b0);
    push_beat(8'h7a, 1'b0);
    push_beat(8'h71, 1'b1);

    // A message that ends right on the tilde, one that ends on the first
    // digit, and a bad second digit that is itself the last byte.
    push_beat(TildeChar, 1'b1);
    push_beat(TildeChar, 1'b0);
    push_beat(Ascii0 + 8'd3, 1'b1);
    push_beat(TildeChar, 1'b0);
    push_beat(Ascii0 + 8'd1, 1'b0);
    push_beat(AsciiUpperF + 8'd1, 1'b1);

    // An escape left open when the mode is rewritten must be forgotten, so
    // the next byte comes out as a plain literal.
    push_beat(TildeChar, 1'b0);
    set_mode(1'b1);
    push_beat(AsciiUpperA, 1'b1);

    // Random traffic, alternating between the two modes.
    for (int p = 0; p < 6; p++) begin
      run_phase(p % 2 == 0);
    end

    drain_and_wait();
    $display("Sent %0d input beats over %0d register writes and %0d idle pauses.",
             items_sent, mode_writes, pauses);
    $display("Checked %0d result beats, %0d of them escape errors.",
             sb.beats_checked, sb.flagged_beats);
    if (sb.mismatches == 0 && sb.pending_beats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog, sized well above the slowest legal run with every long stall
  // and gap landing on escaped bytes.
  initial begin
    #(5_000_000);
    $display("%0t: timeout with %0d result beats still expected",
             $time, sb.pending_beats.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
